/* rtl/sbc_pkg.sv */
// ----------------------------------------------------------------------------
// sbc_pkg
// Shared types, constants and helper functions for the 3D segment/box clipper.
// ----------------------------------------------------------------------------
package sbc_pkg;

  localparam int unsigned COORD_W        = 32;
  localparam int unsigned THR_W          = 31;
  localparam int unsigned NUM_W          = 49;  // |plane - origin| * 2^16
  localparam int unsigned QUO_W          = 32;
  localparam int unsigned DIV_BITS_STAGE = 2;
  localparam int unsigned DIV_STAGES     = QUO_W / DIV_BITS_STAGE;
  localparam int unsigned DIV_LAT        = DIV_STAGES + 1;
  localparam int unsigned PASS_LAT       = DIV_LAT + 4;
  localparam int unsigned MAX_PASSES_DEF = 4;
  localparam int unsigned CFG_IDX_W      = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MIN_Z = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_X = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Y = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_BOX_MAX_Z = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_SMALL_THR = 3'd6;

  // Axis codes
  localparam logic [1:0] AXIS_X = 2'd0;
  localparam logic [1:0] AXIS_Y = 2'd1;
  localparam logic [1:0] AXIS_Z = 2'd2;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] lo;
    logic [2:0][COORD_W-1:0] hi;
    logic [THR_W-1:0]        thr;
  } box_cfg_t;

  typedef struct packed {
    logic [2:0][COORD_W-1:0] org;
    logic [2:0][COORD_W-1:0] dir;
    logic [2:0][COORD_W-1:0] pt;
    logic [5:0]              end_code;
    logic                    done;
    logic                    hit;
  } item_t;

  typedef struct packed {
    item_t               item;
    logic [1:0]          axis;
    logic [COORD_W-1:0]  plane;
    logic                move;
    logic                q_neg;
  } pass_ctx_t;

  function automatic logic [5:0] outcode(input logic [2:0][COORD_W-1:0] p,
                                         input box_cfg_t box);
    logic [5:0] c;
    c = '0;
    for (int a = 0; a < 3; a++) begin
      if ($signed(p[a]) < $signed(box.lo[a])) c[2*a] = 1'b1;
      else if ($signed(p[a]) > $signed(box.hi[a])) c[2*a+1] = 1'b1;
    end
    return c;
  endfunction

  function automatic logic [5:0] facecode(input logic [2:0][COORD_W-1:0] p,
                                          input box_cfg_t box);
    logic [5:0] c;
    c = '0;
    for (int a = 0; a < 3; a++) begin
      if (p[a] == box.lo[a]) c[2*a] = 1'b1;
      else if (p[a] == box.hi[a]) c[2*a+1] = 1'b1;
    end
    return c;
  endfunction

  // One restoring division step: returns {remainder, shifted accumulator}.
  function automatic logic [63:0] div_step(input logic [31:0] rem,
                                           input logic [31:0] acc,
                                           input logic [31:0] den);
    logic [32:0] t;
    logic [33:0] diff;
    logic        ge;
    t    = {rem, acc[31]};
    diff = {1'b0, t} - {2'b00, den};
    ge   = ~diff[33];
    return {(ge ? diff[31:0] : t[31:0]), acc[30:0], ge};
  endfunction

  function automatic logic [COORD_W-1:0] sat32(input logic signed [48:0] v);
    if (v > 49'sd2147483647) return 32'h7FFF_FFFF;
    if (v < -49'sd2147483648) return 32'h8000_0000;
    return v[31:0];
  endfunction

endpackage

/* rtl/sbc_divider.sv */
// ----------------------------------------------------------------------------
// sbc_divider
// Pipelined unsigned restoring divider, two quotient bits per stage.
// ----------------------------------------------------------------------------
module sbc_divider
  import sbc_pkg::*;
#(
  parameter int unsigned PW = 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [NUM_W-1:0] in_num,
  input  logic [31:0]      in_den,
  input  logic [PW-1:0]    in_ctx,
  output logic             out_valid,
  output logic [QUO_W-1:0] out_quo,
  output logic             out_ovf,
  output logic [PW-1:0]    out_ctx
);

  logic [DIV_STAGES:0] v_r;
  logic [31:0]         rem_r [DIV_STAGES+1];
  logic [31:0]         acc_r [DIV_STAGES+1];
  logic [31:0]         den_r [DIV_STAGES+1];
  logic                ovf_r [DIV_STAGES+1];
  logic [PW-1:0]       ctx_r [DIV_STAGES+1];

  // Entry stage: quotient overflow check (num >= den * 2^32)
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else begin
      v_r[0] <= in_valid;
    end
    rem_r[0] <= {15'd0, in_num[NUM_W-1:32]};
    acc_r[0] <= in_num[31:0];
    den_r[0] <= in_den;
    ovf_r[0] <= {15'd0, in_num} >= {in_den, 32'd0};
    ctx_r[0] <= in_ctx;
  end

  for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
    logic [63:0] st1;
    logic [63:0] st2;
    assign st1 = div_step(rem_r[k-1], acc_r[k-1], den_r[k-1]);
    assign st2 = div_step(st1[63:32], st1[31:0], den_r[k-1]);
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else begin
        v_r[k] <= v_r[k-1];
      end
      rem_r[k] <= st2[63:32];
      acc_r[k] <= st2[31:0];
      den_r[k] <= den_r[k-1];
      ovf_r[k] <= ovf_r[k-1];
      ctx_r[k] <= ctx_r[k-1];
    end
  end

  assign out_valid = v_r[DIV_STAGES];
  assign out_quo   = acc_r[DIV_STAGES];
  assign out_ovf   = ovf_r[DIV_STAGES];
  assign out_ctx   = ctx_r[DIV_STAGES];

`ifndef SYNTHESIS
  a_div_lat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, DIV_LAT))
    else $error("divider output without matching input");
  a_div_rem : assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && !ovf_r[0] |-> rem_r[0] < den_r[0])
    else $error("divider start remainder not below divisor");
`endif

endmodule

/* rtl/sbc_clip_pass.sv */
// ----------------------------------------------------------------------------
// sbc_clip_pass
// One clip pass: outcode decision, plane select, divide, multiply, update.
// ----------------------------------------------------------------------------
module sbc_clip_pass
  import sbc_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  box_cfg_t box,
  input  logic     in_valid,
  input  item_t    in_item,
  output logic     out_valid,
  output item_t    out_item
);

  localparam int unsigned CTX_W = $bits(pass_ctx_t);

  // ---- setup stage
  pass_ctx_t          set_ctx;
  logic [NUM_W-1:0]   set_num;
  logic [31:0]        set_den;
  logic [5:0]         code;
  logic [COORD_W-1:0] dsel;
  logic [32:0]        diff;
  logic [32:0]        diff_mag;

  always_comb begin
    set_ctx       = '0;
    set_ctx.item  = in_item;
    code          = outcode(in_item.pt, box);
    dsel          = '0;
    diff          = '0;
    diff_mag      = '0;
    set_num       = '0;
    set_den       = '0;
    if (!in_item.done) begin
      if (code == 6'd0) begin
        set_ctx.item.done = 1'b1;
        set_ctx.item.hit  = 1'b1;
      end else if ((code & in_item.end_code) != 6'd0) begin
        set_ctx.item.done = 1'b1;
        set_ctx.item.hit  = 1'b0;
      end else begin
        if (code[0]) begin
          set_ctx.axis = AXIS_X; set_ctx.plane = box.lo[0];
        end else if (code[1]) begin
          set_ctx.axis = AXIS_X; set_ctx.plane = box.hi[0];
        end else if (code[2]) begin
          set_ctx.axis = AXIS_Y; set_ctx.plane = box.lo[1];
        end else if (code[3]) begin
          set_ctx.axis = AXIS_Y; set_ctx.plane = box.hi[1];
        end else if (code[4]) begin
          set_ctx.axis = AXIS_Z; set_ctx.plane = box.lo[2];
        end else begin
          set_ctx.axis = AXIS_Z; set_ctx.plane = box.hi[2];
        end
        dsel    = in_item.dir[set_ctx.axis];
        set_den = dsel[31] ? (~dsel + 32'd1) : dsel;
        if (set_den <= {1'b0, box.thr}) begin
          // near-zero direction: snap the clipped coordinate only
          set_ctx.item.pt[set_ctx.axis] = set_ctx.plane;
        end else begin
          set_ctx.move  = 1'b1;
          diff          = {set_ctx.plane[31], set_ctx.plane}
                        - {in_item.org[set_ctx.axis][31], in_item.org[set_ctx.axis]};
          diff_mag      = diff[32] ? (~diff + 33'd1) : diff;
          set_num       = {diff_mag, 16'd0};
          set_ctx.q_neg = diff[32] ^ dsel[31];
        end
      end
    end
  end

  logic             set_v_r;
  pass_ctx_t        set_ctx_r;
  logic [NUM_W-1:0] set_num_r;
  logic [31:0]      set_den_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      set_v_r <= 1'b0;
    end else begin
      set_v_r <= in_valid;
    end
    set_ctx_r <= set_ctx;
    set_num_r <= set_num;
    set_den_r <= set_den;
  end

  // ---- divide
  logic             div_v;
  logic [QUO_W-1:0] div_q;
  logic             div_ovf;
  logic [CTX_W-1:0] div_ctx_bits;
  pass_ctx_t        div_ctx;

  sbc_divider #(.PW(CTX_W)) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (set_v_r),
    .in_num    (set_num_r),
    .in_den    (set_den_r),
    .in_ctx    (set_ctx_r),
    .out_valid (div_v),
    .out_quo   (div_q),
    .out_ovf   (div_ovf),
    .out_ctx   (div_ctx_bits)
  );
  assign div_ctx = pass_ctx_t'(div_ctx_bits);

  // ---- signed saturation of the parameter s
  logic [31:0] s_nxt;
  always_comb begin
    if (!div_ctx.q_neg) begin
      s_nxt = (div_ovf || div_q[31]) ? 32'h7FFF_FFFF : div_q;
    end else begin
      s_nxt = (div_ovf || div_q > 32'h8000_0000) ? 32'h8000_0000 : (~div_q + 32'd1);
    end
  end

  logic        sat_v_r;
  pass_ctx_t   sat_ctx_r;
  logic [31:0] s_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sat_v_r <= 1'b0;
    end else begin
      sat_v_r <= div_v;
    end
    sat_ctx_r <= div_ctx;
    s_r       <= s_nxt;
  end

  // ---- multiply the two other direction components by s
  logic [1:0]         o1;
  logic [1:0]         o2;
  logic signed [63:0] p1;
  logic signed [63:0] p2;

  assign o1 = (sat_ctx_r.axis == AXIS_X) ? AXIS_Y : AXIS_X;
  assign o2 = (sat_ctx_r.axis == AXIS_Z) ? AXIS_Y : AXIS_Z;
  assign p1 = $signed(sat_ctx_r.item.dir[o1]) * $signed(s_r);
  assign p2 = $signed(sat_ctx_r.item.dir[o2]) * $signed(s_r);

  logic        mul_v_r;
  pass_ctx_t   mul_ctx_r;
  logic [63:0] p1_r;
  logic [63:0] p2_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mul_v_r <= 1'b0;
    end else begin
      mul_v_r <= sat_v_r;
    end
    mul_ctx_r <= sat_ctx_r;
    p1_r      <= p1;
    p2_r      <= p2;
  end

  // ---- floor, add origin, saturate
  logic [1:0]         f1;
  logic [1:0]         f2;
  logic [48:0]        t1;
  logic [48:0]        t2;
  item_t              fin_item;

  assign f1 = (mul_ctx_r.axis == AXIS_X) ? AXIS_Y : AXIS_X;
  assign f2 = (mul_ctx_r.axis == AXIS_Z) ? AXIS_Y : AXIS_Z;
  assign t1 = {p1_r[63], p1_r[63:16]}
            + {{17{mul_ctx_r.item.org[f1][31]}}, mul_ctx_r.item.org[f1]};
  assign t2 = {p2_r[63], p2_r[63:16]}
            + {{17{mul_ctx_r.item.org[f2][31]}}, mul_ctx_r.item.org[f2]};

  always_comb begin
    fin_item = mul_ctx_r.item;
    if (mul_ctx_r.move) begin
      fin_item.pt[f1]             = sat32($signed(t1));
      fin_item.pt[f2]             = sat32($signed(t2));
      fin_item.pt[mul_ctx_r.axis] = mul_ctx_r.plane;
    end
  end

  logic  fin_v_r;
  item_t fin_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fin_v_r <= 1'b0;
    end else begin
      fin_v_r <= mul_v_r;
    end
    fin_item_r <= fin_item;
  end

  assign out_valid = fin_v_r;
  assign out_item  = fin_item_r;

`ifndef SYNTHESIS
  a_pass_lat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(in_valid, PASS_LAT))
    else $error("pass output without matching input");
  a_pass_done : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && $past(in_item.done, PASS_LAT) |-> out_item == $past(in_item, PASS_LAT))
    else $error("finished item altered by a pass");
`endif

endmodule

/* rtl/segment_box_clip_3d_unit.sv */
// ----------------------------------------------------------------------------
// segment_box_clip_3d_unit
// Outcode clipping of a 3D segment against a configured axis-aligned box.
// ----------------------------------------------------------------------------
// Pipeline: the input register, MAX_PASSES clip passes and the output register
//   lie between the start transfer and the result transfer; each pass is
//   dominated by the 16-stage divider (two quotient bits per stage).
// Throughput: one segment per cycle; busy is never raised, results cannot
//   be stalled by the receiver.
// Reset: synchronous active-low rst_n clears all valid bits and restores
//   the box registers to zero and the threshold to one.
module segment_box_clip_3d_unit
  import sbc_pkg::*;
#(
  parameter int unsigned MAX_PASSES = MAX_PASSES_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_idx,
  input  logic [COORD_W-1:0]   cfg_wdata,
  // command channel
  input  logic                 start,
  output logic                 busy,
  input  logic [COORD_W-1:0]   in_origin_x,
  input  logic [COORD_W-1:0]   in_origin_y,
  input  logic [COORD_W-1:0]   in_origin_z,
  input  logic [COORD_W-1:0]   in_dir_x,
  input  logic [COORD_W-1:0]   in_dir_y,
  input  logic [COORD_W-1:0]   in_dir_z,
  input  logic [COORD_W-1:0]   in_seg_start_x,
  input  logic [COORD_W-1:0]   in_seg_start_y,
  input  logic [COORD_W-1:0]   in_seg_start_z,
  input  logic [COORD_W-1:0]   in_seg_end_x,
  input  logic [COORD_W-1:0]   in_seg_end_y,
  input  logic [COORD_W-1:0]   in_seg_end_z,
  // result channel
  output logic                 out_valid,
  output logic                 out_hit,
  output logic [COORD_W-1:0]   out_clip_x,
  output logic [COORD_W-1:0]   out_clip_y,
  output logic [COORD_W-1:0]   out_clip_z,
  output logic [5:0]           out_face_flags
);

  localparam int unsigned TOTAL_LAT = 2 + MAX_PASSES * PASS_LAT;

  // Fully pipelined: a new segment can be taken on every cycle.
  assign busy = 1'b0;

  // ---- configuration registers
  box_cfg_t box_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      box_r.lo  <= '0;
      box_r.hi  <= '0;
      box_r.thr <= THR_W'(1);
    end else if (cfg_we) begin
      case (cfg_idx)
        CFG_BOX_MIN_X: box_r.lo[0] <= cfg_wdata;
        CFG_BOX_MIN_Y: box_r.lo[1] <= cfg_wdata;
        CFG_BOX_MIN_Z: box_r.lo[2] <= cfg_wdata;
        CFG_BOX_MAX_X: box_r.hi[0] <= cfg_wdata;
        CFG_BOX_MAX_Y: box_r.hi[1] <= cfg_wdata;
        CFG_BOX_MAX_Z: box_r.hi[2] <= cfg_wdata;
        CFG_SMALL_THR: box_r.thr   <= cfg_wdata[THR_W-1:0];
        default: ;
      endcase
    end
  end

  // ---- input stage: capture the transfer, outcode of the segment end
  item_t                   in_item;
  logic [2:0][COORD_W-1:0] seg_end;

  assign seg_end = {in_seg_end_z, in_seg_end_y, in_seg_end_x};

  always_comb begin
    in_item          = '0;
    in_item.org      = {in_origin_z, in_origin_y, in_origin_x};
    in_item.dir      = {in_dir_z, in_dir_y, in_dir_x};
    in_item.pt       = {in_seg_start_z, in_seg_start_y, in_seg_start_x};
    in_item.end_code = outcode(seg_end, box_r);
  end

  logic  in_v_r;
  item_t in_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r <= 1'b0;
    end else begin
      in_v_r <= start && !busy;
    end
    in_item_r <= in_item;
  end

  // ---- chain of clip passes
  logic [MAX_PASSES:0] chain_v;
  item_t               chain_item [MAX_PASSES+1];

  assign chain_v[0]    = in_v_r;
  assign chain_item[0] = in_item_r;

  for (genvar p = 0; p < MAX_PASSES; p++) begin : g_pass
    sbc_clip_pass u_pass (
      .clk       (clk),
      .rst_n     (rst_n),
      .box       (box_r),
      .in_valid  (chain_v[p]),
      .in_item   (chain_item[p]),
      .out_valid (chain_v[p+1]),
      .out_item  (chain_item[p+1])
    );
  end

  // ---- output stage: undecided after all passes counts as a hit
  item_t last_item;
  assign last_item = chain_item[MAX_PASSES];

  logic                    out_v_r;
  logic                    out_hit_r;
  logic [2:0][COORD_W-1:0] out_pt_r;
  logic [5:0]              out_face_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= chain_v[MAX_PASSES];
    end
    out_hit_r  <= last_item.done ? last_item.hit : 1'b1;
    out_pt_r   <= last_item.pt;
    out_face_r <= facecode(last_item.pt, box_r);
  end

  assign out_valid      = out_v_r;
  assign out_hit        = out_hit_r;
  assign out_clip_x     = out_pt_r[0];
  assign out_clip_y     = out_pt_r[1];
  assign out_clip_z     = out_pt_r[2];
  assign out_face_flags = out_face_r;

`ifndef SYNTHESIS
  a_top_lat : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a start transfer");
  a_top_none : assert property (@(posedge clk) disable iff (!rst_n)
    !$past(start && !busy, TOTAL_LAT) |-> !out_valid)
    else $error("result strobe without a start transfer");
  a_top_miss : assert property (@(posedge clk) disable iff (!rst_n)
    chain_v[MAX_PASSES] && !last_item.done |=> out_hit)
    else $error("undecided segment not reported as hit");
`endif

endmodule

/* test/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: segment_box_clip_3d_unit testbench
// Drives segments through the clipper under several box settings and gap
// profiles; each result transfer is checked field by field against an
// in-bench clip predictor or a typed-in value from the directed table run up front.
// ----------------------------------------------------------------------------
module tb;
  import sbc_pkg::*;

  localparam int LIMIT     = 400000;  // cycle limit for the whole run
  localparam int DRAIN     = 120;     // final wait, with margin over the pipeline latency
  localparam int N_PHASES  = 6;
  localparam int PHASE_LEN = 258;     // random items per box setting

  typedef logic [2:0][COORD_W-1:0] coord3_t;
  typedef longint vec3_t[3];

  typedef struct packed {
    coord3_t org;
    coord3_t dir;
    coord3_t sp;
    coord3_t ep;
  } segment_t;

  typedef struct packed {
    logic               hit;
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [COORD_W-1:0] z;
    logic [5:0]         faces;
  } clip_res_t;

  typedef struct packed {
    segment_t  seg;
    logic      known;  // expected value typed in below
    clip_res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx = '0;
  logic [COORD_W-1:0] cfg_wdata = '0;
  logic start = 1'b0;
  logic busy;
  segment_t drv = '0;
  logic out_valid, out_hit;
  logic [COORD_W-1:0] out_clip_x, out_clip_y, out_clip_z;
  logic [5:0] out_face_flags;

  // bench copy of the box registers
  longint box_lo[3] = '{0, 0, 0};
  longint box_hi[3] = '{0, 0, 0};
  longint thr = 1;

  clip_res_t pending_clips[$];
  int errors = 0;
  int cycles = 0;
  int idle_pct = 0;

  always #5 clk = ~clk;

  segment_box_clip_3d_unit DUT (
    .clk, .rst_n, .cfg_we, .cfg_idx, .cfg_wdata, .start, .busy,
    .in_origin_x(drv.org[0]), .in_origin_y(drv.org[1]), .in_origin_z(drv.org[2]),
    .in_dir_x(drv.dir[0]), .in_dir_y(drv.dir[1]), .in_dir_z(drv.dir[2]),
    .in_seg_start_x(drv.sp[0]), .in_seg_start_y(drv.sp[1]), .in_seg_start_z(drv.sp[2]),
    .in_seg_end_x(drv.ep[0]), .in_seg_end_y(drv.ep[1]), .in_seg_end_z(drv.ep[2]),
    .out_valid, .out_hit, .out_clip_x, .out_clip_y, .out_clip_z, .out_face_flags
  );

  // ---------------------------------------------------------------- predictor
  function automatic longint sat_q(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // floor(v / 2^16)
  function automatic longint floor16(longint v);
    if (v >= 0) return v >>> 16;
    return -((-v + 65535) >>> 16);
  endfunction

  function automatic logic [5:0] side_code(vec3_t p);
    logic [5:0] c;
    c = '0;
    for (int a = 0; a < 3; a++) begin
      if (p[a] < box_lo[a]) c[2*a] = 1'b1;
      else if (p[a] > box_hi[a]) c[2*a+1] = 1'b1;
    end
    return c;
  endfunction

  function automatic logic [5:0] face_code(vec3_t p);
    logic [5:0] c;
    c = '0;
    for (int a = 0; a < 3; a++) begin
      if (p[a] == box_lo[a]) c[2*a] = 1'b1;
      else if (p[a] == box_hi[a]) c[2*a+1] = 1'b1;
    end
    return c;
  endfunction

  function automatic clip_res_t clip_segment(segment_t s);
    vec3_t o, d, p, e;
    logic [5:0] ec, pc;
    clip_res_t r;
    int ax;
    longint plane, mag, q;
    for (int a = 0; a < 3; a++) begin
      o[a] = longint'($signed(s.org[a]));
      d[a] = longint'($signed(s.dir[a]));
      p[a] = longint'($signed(s.sp[a]));
      e[a] = longint'($signed(s.ep[a]));
    end
    ec = side_code(e);
    r.hit = 1'b1;
    for (int pass = 0; pass < MAX_PASSES_DEF; pass++) begin
      pc = side_code(p);
      if (pc == 0) begin
        r.hit = 1'b1;
        break;
      end
      if ((pc & ec) != 0) begin
        r.hit = 1'b0;
        break;
      end
      // first violated plane in left, right, bottom, top, back, front order
      if (pc[0]) begin ax = 0; plane = box_lo[0]; end
      else if (pc[1]) begin ax = 0; plane = box_hi[0]; end
      else if (pc[2]) begin ax = 1; plane = box_lo[1]; end
      else if (pc[3]) begin ax = 1; plane = box_hi[1]; end
      else if (pc[4]) begin ax = 2; plane = box_lo[2]; end
      else begin ax = 2; plane = box_hi[2]; end
      mag = d[ax] < 0 ? -d[ax] : d[ax];
      // near-zero direction: snap only the clipped coordinate
      if (mag > thr) begin
        q = sat_q(((plane - o[ax]) * 65536) / d[ax]);
        for (int k = 0; k < 3; k++)
          if (k != ax) p[k] = sat_q(o[k] + floor16(d[k] * q));
      end
      p[ax] = plane;
    end
    r.x = p[0][31:0];
    r.y = p[1][31:0];
    r.z = p[2][31:0];
    r.faces = face_code(p);
    return r;
  endfunction

  // ---------------------------------------------------------------- checking
  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    errors++;
    $display("MISMATCH %s got %h want %h at cycle %0d", what, got, want, cycles);
  endtask

  // outputs are sampled at the edge that ends their valid cycle
  always @(posedge clk) begin
    clip_res_t w;
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
    if (rst_n && out_valid) begin
      if (pending_clips.size() == 0) begin
        report("unexpected result", 32'(out_hit), 32'd0);
      end else begin
        w = pending_clips.pop_front();
        if (out_hit !== w.hit) report("hit", 32'(out_hit), 32'(w.hit));
        if (out_clip_x !== w.x) report("clip_x", out_clip_x, w.x);
        if (out_clip_y !== w.y) report("clip_y", out_clip_y, w.y);
        if (out_clip_z !== w.z) report("clip_z", out_clip_z, w.z);
        if (out_face_flags !== w.faces)
          report("face_flags", 32'(out_face_flags), 32'(w.faces));
      end
    end
  end

  // ---------------------------------------------------------------- driving
  // One start transfer; start stays high on return so back-to-back items
  // never drop it within a time step.
  task automatic send(segment_t s, logic known, clip_res_t res);
    start <= 1'b1;
    drv <= s;
    do @(posedge clk); while (busy);
    pending_clips.push_back(known ? res : clip_segment(s));
  endtask

  task automatic gap();
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic drain_idle();
    start <= 1'b0;
    @(posedge clk);
    while (pending_clips.size() != 0) @(posedge clk);
  endtask

  // write enable stays high on return; set_box drops it after the last write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, longint v);
    cfg_we <= 1'b1;
    cfg_idx <= idx;
    cfg_wdata <= v[31:0];
    @(posedge clk);
    if (idx == CFG_SMALL_THR) thr = v & 64'h7FFF_FFFF;
    else if (idx <= CFG_BOX_MIN_Z) box_lo[idx] = longint'($signed(v[31:0]));
    else box_hi[idx - CFG_BOX_MAX_X] = longint'($signed(v[31:0]));
  endtask

  task automatic set_box(longint lx, longint ly, longint lz,
                         longint hx, longint hy, longint hz, longint t);
    cfg_write(CFG_BOX_MIN_X, lx);
    cfg_write(CFG_BOX_MIN_Y, ly);
    cfg_write(CFG_BOX_MIN_Z, lz);
    cfg_write(CFG_BOX_MAX_X, hx);
    cfg_write(CFG_BOX_MAX_Y, hy);
    cfg_write(CFG_BOX_MAX_Z, hz);
    cfg_write(CFG_SMALL_THR, t);
    cfg_we <= 1'b0;
  endtask

  // ---------------------------------------------------------------- stimulus
  function automatic coord3_t v3(longint x, longint y, longint z);
    coord3_t c;
    c[0] = x[31:0];
    c[1] = y[31:0];
    c[2] = z[31:0];
    return c;
  endfunction

  function automatic coord3_t rnd_full();
    return v3($urandom, $urandom, $urandom);
  endfunction

  // a coordinate around the box span on one axis, wide boxes get full range
  function automatic longint near_box(int a);
    longint lo, hi, span;
    lo = box_lo[a] < box_hi[a] ? box_lo[a] : box_hi[a];
    hi = box_lo[a] < box_hi[a] ? box_hi[a] : box_lo[a];
    if (hi - lo > 64'd16777216) return longint'($signed($urandom));
    span = (hi - lo) / 2 + 64;
    // land exactly on a face now and then
    case ($urandom_range(7))
      0: return lo;
      1: return hi;
      default: return sat_q(lo - span + longint'($urandom_range(0, 32'(hi - lo + 2 * span))));
    endcase
  endfunction

  function automatic coord3_t rnd_near();
    return v3(near_box(0), near_box(1), near_box(2));
  endfunction

  function automatic segment_t rnd_segment();
    segment_t s;
    longint dd;
    int kind;
    kind = $urandom_range(99);
    s.sp = rnd_near();
    s.ep = rnd_near();
    if (kind < 10) begin
      // raw noise on every field
      s = {rnd_full(), rnd_full(), rnd_full(), rnd_full()};
    end else if (kind < 75) begin
      // consistent line: origin at start, direction toward end
      s.org = s.sp;
      for (int a = 0; a < 3; a++) begin
        dd = longint'($signed(s.ep[a])) - longint'($signed(s.sp[a]));
        if ($urandom_range(9) == 0) dd = longint'($urandom_range(0, 3)) - 1;  // near zero
        s.dir[a] = sat_q(dd);
      end
    end else begin
      s.org = rnd_near();
      s.dir = $urandom_range(1) ? rnd_full() : v3($urandom_range(0, 4095) - 2048,
                                                   $urandom_range(0, 4095) - 2048,
                                                   $urandom_range(0, 4095) - 2048);
    end
    return s;
  endfunction

  localparam longint MINV = -64'sd2147483648;
  localparam longint MAXV = 64'sd2147483647;

  dir_row_t dir_rows[$];

  task automatic add_row(coord3_t o, coord3_t d, coord3_t s, coord3_t e,
                         logic known, logic h, longint x, longint y, longint z,
                         logic [5:0] f);
    dir_row_t r;
    r.seg = {o, d, s, e};
    r.known = known;
    r.res = {h, x[31:0], y[31:0], z[31:0], f};
    dir_rows.push_back(r);
  endtask

  initial begin
    segment_t s;
    // reset box is the single point at zero, threshold one
    // point at the box: inside, on all min faces
    add_row(v3(0,0,0), v3(0,0,0), v3(0,0,0), v3(0,0,0), 1, 1, 0, 0, 0, 6'h15);
    // both ends left: miss at the start point
    add_row(v3(0,0,0), v3(0,0,0), v3(-5,0,0), v3(-5,0,0), 1, 0, -5, 0, 0, 6'h14);
    // most negative everywhere: miss, on no face
    add_row(v3(MINV,MINV,MINV), v3(MINV,MINV,MINV), v3(MINV,MINV,MINV),
            v3(MINV,MINV,MINV), 1, 0, MINV, MINV, MINV, 6'h00);
    // most positive everywhere: miss
    add_row(v3(MAXV,MAXV,MAXV), v3(MAXV,MAXV,MAXV), v3(MAXV,MAXV,MAXV),
            v3(MAXV,MAXV,MAXV), 1, 0, MAXV, MAXV, MAXV, 6'h00);
    // zero direction across x, y and z: coordinate snaps to the plane
    add_row(v3(0,0,0), v3(0,0,0), v3(-100,0,0), v3(100,0,0), 1, 1, 0, 0, 0, 6'h15);
    add_row(v3(0,0,0), v3(0,0,0), v3(0,-100,0), v3(0,100,0), 1, 1, 0, 0, 0, 6'h15);
    add_row(v3(0,0,0), v3(0,0,0), v3(0,100,0), v3(0,-100,0), 1, 1, 0, 0, 0, 6'h15);
    add_row(v3(0,0,0), v3(0,0,0), v3(0,0,-100), v3(0,0,100), 1, 1, 0, 0, 0, 6'h15);
    add_row(v3(0,0,0), v3(0,0,0), v3(0,0,100), v3(0,0,-100), 1, 1, 0, 0, 0, 6'h15);
    // direction at the threshold still snaps
    add_row(v3(0,0,0), v3(1,-1,1), v3(100,0,0), v3(-100,0,0), 1, 1, 0, 0, 0, 6'h15);
    // full intersections, saturation and pass exhaustion left to the predictor
    add_row(v3(-65536,-65536,-65536), v3(65536,65536,65536), v3(-65536,-65536,-65536),
            v3(65536,65536,65536), 0, 0, 0, 0, 0, 0);
    add_row(v3(MINV,0,MAXV), v3(2,MAXV,MINV), v3(MINV,-7,MAXV), v3(MAXV,7,MINV),
            0, 0, 0, 0, 0, 0);
    add_row(v3(-3,5,-9), v3(MAXV,MINV,MAXV), v3(-3,5,-9), v3(3,-5,9), 0, 0, 0, 0, 0, 0);
    add_row(v3(-1,-1,-1), v3(2,2,2), v3(-1,-1,-1), v3(1,1,1), 0, 0, 0, 0, 0, 0);
    add_row(v3(MAXV,MAXV,MINV), v3(MINV,MINV,MAXV), v3(MAXV,MAXV,MINV),
            v3(MINV,MINV,MAXV), 0, 0, 0, 0, 0, 0);

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed table under the reset box
    foreach (dir_rows[i]) send(dir_rows[i].seg, dir_rows[i].known, dir_rows[i].res);
    drain_idle();

    for (int ph = 0; ph < N_PHASES; ph++) begin
      longint lo[3], hi[3];
      for (int a = 0; a < 3; a++) begin
        lo[a] = longint'($urandom_range(0, 2097152)) - 1048576;
        hi[a] = lo[a] + $urandom_range(0, 1048576);
      end
      case (ph)
        0: set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(0, 255));
        1: set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2], $urandom_range(0, 200000));
        2: set_box(MINV, MINV, MINV, MAXV, MAXV, MAXV, 0);
        // inverted box on every axis
        3: set_box(hi[0] + 1, hi[1] + 1, hi[2] + 1, lo[0], lo[1], lo[2], MAXV);
        // flat box: each axis collapsed to one plane
        4: set_box(lo[0], lo[1], lo[2], lo[0], lo[1], lo[2], 1);
        default: set_box(lo[0], lo[1], lo[2], hi[0], hi[1], hi[2],
                         $urandom_range(0, 7) == 0 ? 0 : $urandom_range(0, 65536));
      endcase
      // sender gap profile per phase: none, 46 percent, 6 percent
      case (ph % 3)
        0: idle_pct = 0;
        1: idle_pct = 46;
        default: idle_pct = 6;
      endcase
      for (int n = 0; n < PHASE_LEN; n++) begin
        s = rnd_segment();
        send(s, 1'b0, '0);
        // hold off mid-phase until the pipeline is empty
        if (n == PHASE_LEN / 2) drain_idle();
        gap();
      end
      drain_idle();
    end

    repeat (DRAIN) @(posedge clk);
    if (errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/sbc_pkg.sv
rtl/sbc_divider.sv
rtl/sbc_clip_pass.sv
rtl/segment_box_clip_3d_unit.sv
test/tb.sv
